### hdl/integer_to_ascii_formatter_defines.svh
// Assertion macros shared by the checker files of the integer-to-ASCII formatter.
// Depends on nothing; included by bare file name.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Concurrent assertion that is switched off while reset is high.
`define ITAF_ASSERT_DIS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is high.
`define ITAF_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/itaf_pkg.sv
// Shared types, constants and functions of the integer-to-ASCII formatter.
// Depends on nothing; used by every module through scoped names.
package itaf_pkg;

   // Default width of the formatted number.
   localparam int unsigned VALUE_BITS_DEFAULT = 32;

   // Depth of the queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 2;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A_LOW = 8'h61;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_X     = 8'h78;

   localparam logic [3:0] DIGIT_MASK = 4'hf;
   localparam logic [3:0] DEC_BASE   = 4'd10;

   // Double-dabble correction: a BCD digit of five or more gets three added.
   localparam logic [3:0] DD_THRESH = 4'd5;
   localparam logic [3:0] DD_ADJUST = 4'd3;

   // Format selector.
   typedef enum logic [1:0] {
      FMT_SDEC = 2'd0,
      FMT_UDEC = 2'd1,
      FMT_HEX  = 2'd2,
      FMT_PTR  = 2'd3
   } fmt_type;

   // Back-part sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_CONV,
      ST_PFX0,
      ST_PFXX,
      ST_EMIT
   } state_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // ASCII code of one digit, decimal or lower-case hex.
   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [3:0] m;
      m = d & DIGIT_MASK;
      if (m < DEC_BASE) begin
         return CHAR_ZERO + {4'h0, m};
      end else begin
         return CHAR_A_LOW + {4'h0, m} - {4'h0, DEC_BASE};
      end
   endfunction

endpackage

### hdl/itaf_front.sv
// Front part: accepts transactions, classifies them and forms the queue entry.
// Depends on itaf_pkg.
module itaf_front #(
   parameter int unsigned VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_func,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  itaf_pkg::fifo_stat_type q_stat,
   output logic                    q_push,
   output logic [VALUE_BITS+2:0]   q_wdata
);

   logic                  neg;
   logic [VALUE_BITS-1:0] mag;

   // A full queue holds the requester off.
   assign req_stall = q_stat.full;
   assign q_push    = req_valid && !q_stat.full;

   // Signed mode with the sign bit set is printed as '-' and the magnitude.
   always_comb begin
      neg = (itaf_pkg::fmt_type'(req_func) == itaf_pkg::FMT_SDEC)
            && req_value[VALUE_BITS-1];
      mag = neg ? (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;
   end

   // Entry layout: sign flag, format, magnitude.
   assign q_wdata = {neg, req_func, mag};

endmodule

### hdl/itaf_queue.sv
// Short register queue between the front and back parts.
// Depends on itaf_pkg for the status type.
module itaf_queue #(
   parameter int unsigned WIDTH = 35,
   parameter int unsigned DEPTH = itaf_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        wdata,
   input  logic                    pop,
   output logic [WIDTH-1:0]        rdata,
   output itaf_pkg::fifo_stat_type stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### hdl/itaf_back.sv
// Back part: binary-to-BCD conversion and character sequencing into the result register.
// Depends on itaf_pkg.
module itaf_back #(
   parameter int unsigned VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  itaf_pkg::fifo_stat_type q_stat,
   input  logic [VALUE_BITS+2:0]   q_rdata,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_char_code,
   output logic                    rsp_last
);

   localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int unsigned DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned PAD_BITS   = 4 * HEX_DIGITS;
   localparam int unsigned DW         = 4 * DEC_DIGITS;
   localparam int unsigned ALIGN      = DW - PAD_BITS;
   localparam int unsigned CNT_W      = $clog2(DEC_DIGITS + 1);

   itaf_pkg::state_type state_ff, state_in;
   logic [DW-1:0]       dig_ff, dig_in;
   logic [PAD_BITS-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                skip_ff, skip_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                  slot_free;
   logic [3:0]            top_digit;
   logic                  hold;
   logic                  cnt_one;
   logic                  in_neg;
   itaf_pkg::fmt_type     in_mode;
   logic [VALUE_BITS-1:0] in_mag;
   logic [DW-1:0]         dd_dig;
   logic [PAD_BITS-1:0]   dd_bin;
   logic                  emit;
   logic [7:0]            emit_char;
   logic                  emit_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_digit = dig_ff[DW-1 -: 4];
   assign cnt_one   = (cnt_ff == CNT_W'(1));
   assign hold      = skip_ff && (top_digit == 4'h0) && !cnt_one;
   assign in_neg    = q_rdata[VALUE_BITS+2];
   assign in_mode   = itaf_pkg::fmt_type'(q_rdata[VALUE_BITS+1:VALUE_BITS]);
   assign in_mag    = q_rdata[VALUE_BITS-1:0];

   // Four double-dabble steps per cycle: correct each BCD digit, then shift one bit in.
   always_comb begin
      dd_dig = dig_ff;
      dd_bin = bin_ff;
      for (int s = 0; s < 4; s++) begin
         for (int k = 0; k < DEC_DIGITS; k++) begin
            if (dd_dig[4*k +: 4] >= itaf_pkg::DD_THRESH) begin
               dd_dig[4*k +: 4] = dd_dig[4*k +: 4] + itaf_pkg::DD_ADJUST;
            end
         end
         dd_dig = {dd_dig[DW-2:0], dd_bin[PAD_BITS-1]};
         dd_bin = {dd_bin[PAD_BITS-2:0], 1'b0};
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itaf_pkg::ST_IDLE: begin
            if (!q_stat.empty) begin
               unique case (in_mode)
                  itaf_pkg::FMT_SDEC: state_in = in_neg ? itaf_pkg::ST_SIGN
                                                        : itaf_pkg::ST_CONV;
                  itaf_pkg::FMT_UDEC: state_in = itaf_pkg::ST_CONV;
                  itaf_pkg::FMT_HEX:  state_in = itaf_pkg::ST_EMIT;
                  itaf_pkg::FMT_PTR:  state_in = itaf_pkg::ST_PFX0;
               endcase
            end
         end
         itaf_pkg::ST_SIGN: begin
            if (slot_free) begin
               state_in = itaf_pkg::ST_CONV;
            end
         end
         itaf_pkg::ST_CONV: begin
            if (cnt_one) begin
               state_in = itaf_pkg::ST_EMIT;
            end
         end
         itaf_pkg::ST_PFX0: begin
            if (slot_free) begin
               state_in = itaf_pkg::ST_PFXX;
            end
         end
         itaf_pkg::ST_PFXX: begin
            if (slot_free) begin
               state_in = itaf_pkg::ST_EMIT;
            end
         end
         itaf_pkg::ST_EMIT: begin
            if (!hold && slot_free && cnt_one) begin
               state_in = itaf_pkg::ST_IDLE;
            end
         end
         default: state_in = itaf_pkg::ST_IDLE;
      endcase
   end

   // Datapath loads, queue pop and character selection.
   always_comb begin
      dig_in    = dig_ff;
      bin_in    = bin_ff;
      cnt_in    = cnt_ff;
      skip_in   = skip_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_char = itaf_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      unique case (state_ff)
         itaf_pkg::ST_IDLE: begin
            q_pop = !q_stat.empty;
            if (in_mode == itaf_pkg::FMT_SDEC || in_mode == itaf_pkg::FMT_UDEC) begin
               dig_in  = '0;
               bin_in  = PAD_BITS'(in_mag);
               cnt_in  = CNT_W'(HEX_DIGITS);
               skip_in = 1'b1;
            end else begin
               dig_in  = DW'(PAD_BITS'(in_mag)) << ALIGN;
               bin_in  = '0;
               cnt_in  = CNT_W'(HEX_DIGITS);
               skip_in = (in_mode == itaf_pkg::FMT_HEX);
            end
         end
         itaf_pkg::ST_SIGN: begin
            emit      = slot_free;
            emit_char = itaf_pkg::CHAR_MINUS;
         end
         itaf_pkg::ST_CONV: begin
            dig_in = dd_dig;
            bin_in = dd_bin;
            cnt_in = cnt_one ? CNT_W'(DEC_DIGITS) : cnt_ff - 1'b1;
         end
         itaf_pkg::ST_PFX0: begin
            emit      = slot_free;
            emit_char = itaf_pkg::CHAR_ZERO;
         end
         itaf_pkg::ST_PFXX: begin
            emit      = slot_free;
            emit_char = itaf_pkg::CHAR_X;
         end
         itaf_pkg::ST_EMIT: begin
            emit_char = itaf_pkg::hex_char(top_digit);
            emit_last = cnt_one;
            if (hold) begin
               // Leading zero: drop it without producing a character.
               dig_in = {dig_ff[DW-5:0], 4'h0};
               cnt_in = cnt_ff - 1'b1;
            end else if (slot_free) begin
               emit    = 1'b1;
               dig_in  = {dig_ff[DW-5:0], 4'h0};
               cnt_in  = cnt_ff - 1'b1;
               skip_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: loaded on a new character, emptied when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itaf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      bin_ff      <= bin_in;
      cnt_ff      <= cnt_in;
      skip_ff     <= skip_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### hdl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: front part, queue and back part.
// Depends on itaf_pkg, itaf_front, itaf_queue and itaf_back.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_stall  | req_func, req_value
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_char_code, rsp_last
//
// Hex: after the entry is popped, the digits are sent; pointer form first sends the 0x prefix.
// Decimal: after the entry is popped, the BCD conversion runs (four double-dabble steps a cycle),
// then the digits are sent from the BCD digit positions; a minus sign, if any, goes first.
// The back part sends at most one character a cycle through its result register.
// Reset is synchronous and clears the queue, the sequencer and the result valid.
// A stall on the result side fills the two-entry queue before req_stall rises.
module integer_to_ascii_formatter #(
   parameter int unsigned VALUE_BITS = itaf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char_code,
   output logic                  rsp_last
);

   localparam int unsigned ENTRY_W = VALUE_BITS + 3;

   itaf_pkg::fifo_stat_type q_stat;
   logic                    q_push;
   logic                    q_pop;
   logic [ENTRY_W-1:0]      q_wdata;
   logic [ENTRY_W-1:0]      q_rdata;

   // Classification of incoming transactions.
   itaf_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_value (req_value),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // Decoupling queue.
   itaf_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (itaf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   // Conversion and character output.
   itaf_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .q_rdata       (q_rdata),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

endmodule

### hdl/itaf_checker.sv
// Port-level checks on the result channel of the integer-to-ASCII formatter, with its bind.
// Depends on itaf_pkg and integer_to_ascii_formatter_defines.svh.
`include "integer_to_ascii_formatter_defines.svh"

module itaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_char_code,
   input logic       rsp_last
);

   // Reset empties the result register.
   `ITAF_ASSERT_CLK(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

   // A stalled transaction stays offered unchanged.
   `ITAF_ASSERT_DIS(a_stall_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last), "stalled result changed")

   // Only digits, lower-case hex letters, the minus sign and the x of the prefix appear.
   `ITAF_ASSERT_DIS(a_char_set, clock, reset, rsp_valid |-> (rsp_char_code >= itaf_pkg::CHAR_ZERO && rsp_char_code <= itaf_pkg::CHAR_ZERO + 8'd9) || (rsp_char_code >= itaf_pkg::CHAR_A_LOW && rsp_char_code <= itaf_pkg::CHAR_A_LOW + 8'd5) || rsp_char_code == itaf_pkg::CHAR_MINUS || rsp_char_code == itaf_pkg::CHAR_X, "unexpected character code")

   // A sign or a prefix letter is never the final character of a number.
   `ITAF_ASSERT_DIS(a_prefix_not_last, clock, reset, rsp_valid && (rsp_char_code == itaf_pkg::CHAR_MINUS || rsp_char_code == itaf_pkg::CHAR_X) |-> !rsp_last, "sign or prefix flagged as last")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);
